// ===== src/mck_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    localparam int DATA_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int TABLE_SYMS  = 4;
    localparam int MAX_SYMBOLS = 4;
    localparam int CNT_W       = $clog2(TABLE_SYMS + 1);
    localparam int SYM_IDX_W   = $clog2(TABLE_SYMS);
    localparam int LETTER_W    = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic SYM_DOT  = 1'b0;
    localparam logic SYM_DASH = 1'b1;

    localparam logic [DATA_W-1:0] DOT_LENGTH_RESET  = 16'd100;
    localparam logic [DATA_W-1:0] DASH_LENGTH_RESET = 16'd300;
    localparam logic [DATA_W-1:0] LETTER_GAP_RESET  = 16'd300;
    localparam logic [DATA_W-1:0] WORD_GAP_RESET    = 16'd700;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DOT_LENGTH  = 2'd0,
        REG_DASH_LENGTH = 2'd1,
        REG_LETTER_GAP  = 2'd2,
        REG_WORD_GAP    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0] dot_length;
        logic [DATA_W-1:0] dash_length;
        logic [DATA_W-1:0] letter_gap;
        logic [DATA_W-1:0] word_gap;
    } timing_cfg_t;

    // Bit i of the pattern is the kind of symbol i, sent from bit 0 upward.
    typedef struct packed {
        logic [CNT_W-1:0]      len;
        logic [TABLE_SYMS-1:0] pattern;
    } morse_code_t;

    typedef struct packed {
        logic                  is_space;
        logic [CNT_W-1:0]      count;
        logic [TABLE_SYMS-1:0] pattern;
    } seg_job_t;

    function automatic morse_code_t letter_code(input logic [LETTER_W-1:0] idx);
        morse_code_t code;
        code = '{len: 3'd0, pattern: 4'b0000};
        case (idx)
            5'd0:    code = '{len: 3'd2, pattern: 4'b0010};
            5'd1:    code = '{len: 3'd4, pattern: 4'b0001};
            5'd2:    code = '{len: 3'd4, pattern: 4'b0101};
            5'd3:    code = '{len: 3'd3, pattern: 4'b0001};
            5'd4:    code = '{len: 3'd1, pattern: 4'b0000};
            5'd5:    code = '{len: 3'd4, pattern: 4'b0100};
            5'd6:    code = '{len: 3'd3, pattern: 4'b0011};
            5'd7:    code = '{len: 3'd4, pattern: 4'b0000};
            5'd8:    code = '{len: 3'd2, pattern: 4'b0000};
            5'd9:    code = '{len: 3'd4, pattern: 4'b1110};
            5'd10:   code = '{len: 3'd3, pattern: 4'b0101};
            5'd11:   code = '{len: 3'd4, pattern: 4'b0010};
            5'd12:   code = '{len: 3'd2, pattern: 4'b0011};
            5'd13:   code = '{len: 3'd2, pattern: 4'b0001};
            5'd14:   code = '{len: 3'd3, pattern: 4'b0111};
            5'd15:   code = '{len: 3'd4, pattern: 4'b0110};
            5'd16:   code = '{len: 3'd4, pattern: 4'b1011};
            5'd17:   code = '{len: 3'd3, pattern: 4'b0010};
            5'd18:   code = '{len: 3'd3, pattern: 4'b0000};
            5'd19:   code = '{len: 3'd1, pattern: 4'b0001};
            5'd20:   code = '{len: 3'd3, pattern: 4'b0100};
            5'd21:   code = '{len: 3'd4, pattern: 4'b1000};
            5'd22:   code = '{len: 3'd3, pattern: 4'b0110};
            5'd23:   code = '{len: 3'd4, pattern: 4'b1001};
            5'd24:   code = '{len: 3'd4, pattern: 4'b1101};
            5'd25:   code = '{len: 3'd4, pattern: 4'b0011};
            default: code = '{len: 3'd0, pattern: 4'b0000};
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== src/mck_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mck_front #(
    parameter int MAX_SYMBOLS = mck_pkg::MAX_SYMBOLS
) (
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mck_pkg::CHAR_W-1:0]   character,
    output logic                              push,
    output mck_pkg::seg_job_t                 push_job,
    input  wire logic                         queue_full
);

    mck_pkg::morse_code_t code;
    logic [mck_pkg::CHAR_W-1:0] letter_offset;

    assign in_ready      = !queue_full;
    assign push          = in_valid && !queue_full;
    assign letter_offset = character - mck_pkg::CHAR_A;

    always_comb
    begin
        code     = mck_pkg::letter_code(letter_offset[mck_pkg::LETTER_W-1:0]);
        push_job = '{is_space: 1'b0, count: '0, pattern: '0};
        if (character == mck_pkg::CHAR_SPACE)
        begin
            push_job.is_space = 1'b1;
        end
        else if (character inside {[mck_pkg::CHAR_A:mck_pkg::CHAR_Z]})
        begin
            push_job.pattern = code.pattern;
            if (code.len > mck_pkg::CNT_W'(MAX_SYMBOLS))
            begin
                push_job.count = mck_pkg::CNT_W'(MAX_SYMBOLS);
            end
            else
            begin
                push_job.count = code.len;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/mck_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mck_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mck_pkg::seg_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output mck_pkg::seg_job_t      pop_job
);

    localparam int DEPTH = mck_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    mck_pkg::seg_job_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/mck_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mck_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mck_pkg::timing_cfg_t         timing,
    input  wire logic                         job_valid,
    input  wire mck_pkg::seg_job_t            job,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              led_lit,
    output logic [mck_pkg::DATA_W-1:0]        duration,
    output logic                              last_segment
);

    mck_pkg::seg_job_t job_reg;
    logic                      active_reg, active_next;
    logic [mck_pkg::CNT_W-1:0] sym_reg, sym_next;
    logic                      gap_reg, gap_next;
    logic                      out_valid_reg;
    logic                      led_lit_reg;
    logic [mck_pkg::DATA_W-1:0] duration_reg;
    logic                      last_segment_reg;

    logic                      load_ok;
    logic                      advance;
    logic                      seg_lit;
    logic [mck_pkg::DATA_W-1:0] seg_len;
    logic                      seg_last;

    assign load_ok = !out_valid_reg || out_ready;
    assign advance = active_reg && load_ok;
    assign pop     = job_valid && (!active_reg || (advance && seg_last));

    always_comb
    begin
        seg_lit  = 1'b0;
        seg_len  = timing.letter_gap;
        seg_last = 1'b1;
        if (job_reg.is_space)
        begin
            seg_len = timing.word_gap;
        end
        else if (sym_reg < job_reg.count)
        begin
            seg_last = 1'b0;
            if (gap_reg)
            begin
                seg_len = timing.dot_length;
            end
            else
            begin
                seg_lit = 1'b1;
                if (job_reg.pattern[sym_reg[mck_pkg::SYM_IDX_W-1:0]] == mck_pkg::SYM_DASH)
                begin
                    seg_len = timing.dash_length;
                end
                else
                begin
                    seg_len = timing.dot_length;
                end
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        sym_next    = sym_reg;
        gap_next    = gap_reg;
        if (advance)
        begin
            if (seg_last)
            begin
                active_next = 1'b0;
            end
            else if (gap_reg)
            begin
                gap_next = 1'b0;
                sym_next = sym_reg + 1'b1;
            end
            else
            begin
                gap_next = 1'b1;
            end
        end
        if (pop)
        begin
            active_next = 1'b1;
            sym_next    = '0;
            gap_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            sym_reg       <= '0;
            gap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            sym_reg    <= sym_next;
            gap_reg    <= gap_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        if (advance)
        begin
            led_lit_reg      <= seg_lit;
            duration_reg     <= seg_len;
            last_segment_reg <= seg_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign led_lit      = led_lit_reg;
    assign duration     = duration_reg;
    assign last_segment = last_segment_reg;

endmodule

`default_nettype wire

// ===== src/morse_character_keyer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keys ASCII characters in International Morse code as a run of LED timing items, each
// a level, a duration in time units and a flag on the final item of its character. A
// space gives one dark item of word_gap length; a letter A to Z gives a lit item per dot
// or dash followed by a dark dot-length gap, then a dark letter_gap item; any other code
// gives the letter_gap item alone. A character is accepted into a two-entry queue and
// produces 1 to 9 output items, one per cycle from the segment sequencer while out_ready
// is held high. When the keyer is idle, a character is written into the queue, popped into
// the sequencer's job register, and its first item is then registered onto the output. Timing
// registers are written through the configuration channel, which is always ready.

module morse_character_keyer #(
    parameter int MAX_SYMBOLS = mck_pkg::MAX_SYMBOLS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mck_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mck_pkg::DATA_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [mck_pkg::CHAR_W-1:0]          character,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     led_lit,
    output logic [mck_pkg::DATA_W-1:0]               duration,
    output logic                                     last_segment
);

    mck_pkg::timing_cfg_t timing_reg;
    mck_pkg::seg_job_t    push_job;
    mck_pkg::seg_job_t    pop_job;
    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 pop_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.dot_length  <= mck_pkg::DOT_LENGTH_RESET;
            timing_reg.dash_length <= mck_pkg::DASH_LENGTH_RESET;
            timing_reg.letter_gap  <= mck_pkg::LETTER_GAP_RESET;
            timing_reg.word_gap    <= mck_pkg::WORD_GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (mck_pkg::cfg_index_t'(cfg_index))
                mck_pkg::REG_DOT_LENGTH:  timing_reg.dot_length  <= cfg_data;
                mck_pkg::REG_DASH_LENGTH: timing_reg.dash_length <= cfg_data;
                mck_pkg::REG_LETTER_GAP:  timing_reg.letter_gap  <= cfg_data;
                mck_pkg::REG_WORD_GAP:    timing_reg.word_gap    <= cfg_data;
                default:                  timing_reg             <= timing_reg;
            endcase
        end
    end

    mck_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    mck_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    mck_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .timing       (timing_reg),
        .job_valid    (pop_valid),
        .job          (pop_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .led_lit      (led_lit),
        .duration     (duration),
        .last_segment (last_segment)
    );

endmodule

`default_nettype wire
